// ===== rtl/smpq_pkg.sv =====
package smpq_pkg;

	localparam int QUEUE_DEPTH  = 256;
	localparam int HANDLE_WIDTH = 12;
	localparam int COUNT_W      = $clog2(QUEUE_DEPTH + 1);

	// operation codes
	typedef enum logic {
		OP_OFFER = 1'b0,
		OP_POLL  = 1'b1
	} op_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// one stored entry
	typedef struct packed {
		logic [31:0]             prio;
		logic [15:0]             sym;
		logic [HANDLE_WIDTH-1:0] c0;
		logic [HANDLE_WIDTH-1:0] c1;
	} entry_t;

	// per-cell control from the top level
	typedef struct packed {
		logic en;            // an item is transferred this cycle and changes the queue (not a refused offer or an empty poll)
		logic poll;          // shift toward the head
		logic occ;           // this cell holds an entry
		logic prev_occ;      // cell toward the head holds an entry (head: always)
		logic prev_greater;  // cell toward the head moves back on this offer
	} cell_ctrl_t;

endpackage

// ===== rtl/smpq_cell.sv =====
module smpq_cell (
	input  logic               clk,
	input  smpq_pkg::cell_ctrl_t ctrl,
	input  smpq_pkg::entry_t   new_entry,
	input  smpq_pkg::entry_t   prev_entry,
	input  smpq_pkg::entry_t   next_entry,
	output smpq_pkg::entry_t   cur_entry,
	output logic               greater
);
	import smpq_pkg::*;

	entry_t entry_q;

	// held entry leaves after the offered key
	assign greater   = ctrl.occ && (entry_q.prio > new_entry.prio);
	assign cur_entry = entry_q;

	// shift toward the head on poll, make room and insert on offer
	always_ff @(posedge clk) begin
		if (ctrl.en) begin
			if (ctrl.poll) begin
				entry_q <= next_entry;
			end else if (ctrl.occ && !greater) begin
				entry_q <= entry_q;
			end else if (ctrl.prev_greater) begin
				entry_q <= prev_entry;
			end else if (ctrl.prev_occ) begin
				entry_q <= new_entry;
			end
		end
	end

endmodule

// ===== rtl/stable_min_priority_queue_unit.sv =====
// Sorted min-priority queue of up to QUEUE_DEPTH entries built as a row of cells, the head cell
// always holding the next entry to leave; equal priorities leave in arrival order. An offer
// compares its key in every cell at once and the cells behind the insertion point move back one
// place; a poll shifts every cell one place toward the head. One item can be taken in every
// cycle while the output allows it: the result goes to an output register, so input is taken
// whenever that register is empty or being drained in the same cycle. No clearing pass after reset.
module stable_min_priority_queue_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [31:0] priority_req,
	input  logic [15:0] symbol,
	input  logic [11:0] child_zero,
	input  logic [11:0] child_one,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [31:0] out_priority,
	output logic [15:0] out_symbol,
	output logic [11:0] out_child_zero,
	output logic [11:0] out_child_one,
	output logic [8:0]  entry_count
);
	import smpq_pkg::*;

	logic [COUNT_W-1:0] count_q;
	logic               out_valid_q;
	status_t            status_q;
	entry_t             res_q;
	logic [COUNT_W-1:0] res_count_q;

	logic                     in_fire;
	logic                     is_poll;
	logic                     is_full;
	logic                     is_empty;
	entry_t                   new_entry;
	entry_t [QUEUE_DEPTH-1:0] cells;
	logic   [QUEUE_DEPTH-1:0] greater;
	logic   [QUEUE_DEPTH-1:0] occ;

	// handshake
	assign in_ready = !out_valid_q || out_ready;
	assign in_fire  = in_valid && in_ready;
	assign is_poll  = (op_t'(operation) == OP_POLL);
	assign is_full  = (count_q == COUNT_W'(QUEUE_DEPTH));
	assign is_empty = (count_q == '0);

	// offered entry with handles masked to the stored width
	assign new_entry.prio = priority_req;
	assign new_entry.sym  = symbol;
	assign new_entry.c0   = HANDLE_WIDTH'(child_zero);
	assign new_entry.c1   = HANDLE_WIDTH'(child_one);

	// row of cells
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		cell_ctrl_t ctrl;
		entry_t     prev_e;
		entry_t     next_e;

		assign occ[i] = (COUNT_W'(i) < count_q);

		assign ctrl.en   = in_fire && (is_poll ? !is_empty : !is_full);
		assign ctrl.poll = is_poll;
		assign ctrl.occ  = occ[i];

		if (i == 0) begin : g_head
			assign ctrl.prev_occ     = 1'b1;
			assign ctrl.prev_greater = 1'b0;
			assign prev_e            = new_entry;
		end else begin : g_body
			assign ctrl.prev_occ     = occ[i-1];
			assign ctrl.prev_greater = greater[i-1];
			assign prev_e            = cells[i-1];
		end

		if (i == QUEUE_DEPTH - 1) begin : g_tail
			assign next_e = cells[i];
		end else begin : g_inner
			assign next_e = cells[i+1];
		end

		smpq_cell u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.new_entry  (new_entry),
			.prev_entry (prev_e),
			.next_entry (next_e),
			.cur_entry  (cells[i]),
			.greater    (greater[i])
		);
	end

	// held count and result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (in_fire) begin
				out_valid_q <= 1'b1;
				if (is_poll && !is_empty) begin
					count_q <= count_q - COUNT_W'(1);
				end else if (!is_poll && !is_full) begin
					count_q <= count_q + COUNT_W'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (is_poll) begin
				if (is_empty) begin
					status_q    <= ST_EMPTY;
					res_q       <= '0;
					res_count_q <= '0;
				end else begin
					status_q    <= ST_OK;
					res_q       <= cells[0];
					res_count_q <= count_q - COUNT_W'(1);
				end
			end else begin
				res_q <= '0;
				if (is_full) begin
					status_q    <= ST_FULL;
					res_count_q <= count_q;
				end else begin
					status_q    <= ST_OK;
					res_count_q <= count_q + COUNT_W'(1);
				end
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign out_priority   = res_q.prio;
	assign out_symbol     = res_q.sym;
	assign out_child_zero = 12'(res_q.c0);
	assign out_child_one  = 12'(res_q.c1);
	assign entry_count    = 9'(res_count_q);

	// count stays within the depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(QUEUE_DEPTH))
		else $error("held count above queue depth");

	// head pair stays in order
	a_head_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		occ[1] |-> (cells[0].prio <= cells[1].prio))
		else $error("head cells out of order");

	// poll on empty reports empty
	a_poll_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && is_poll && is_empty) |=> (status_q == ST_EMPTY && count_q == '0))
		else $error("empty poll not reported");

	// accepted offer grows the count by one
	a_offer_count: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !is_poll && !is_full) |=> (count_q == $past(count_q) + COUNT_W'(1)))
		else $error("offer did not grow count");

endmodule

// ===== dv/smpq_result_checker.sv =====
module smpq_result_checker
	import smpq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic        operation,
	input  logic [31:0] priority_req,
	input  logic [15:0] symbol,
	input  logic [11:0] child_zero,
	input  logic [11:0] child_one,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic [1:0]  status,
	input  logic [31:0] out_priority,
	input  logic [15:0] out_symbol,
	input  logic [11:0] out_child_zero,
	input  logic [11:0] out_child_one,
	input  logic [8:0]  entry_count,
	output int unsigned mismatch_count,
	output int unsigned pending_count,
	output int unsigned offer_count,
	output int unsigned poll_count,
	output int unsigned empty_count,
	output int unsigned full_count,
	output int unsigned peak_depth
);

	// one predicted result
	typedef struct {
		status_t     st;
		logic [31:0] prio;
		logic [15:0] sym;
		logic [11:0] c0;
		logic [11:0] c1;
		logic [8:0]  count;
	} queue_result_t;

	// model contents, sorted by priority with ties in arrival order
	entry_t        held_entries[$];
	queue_result_t expected_results[$];
	int unsigned   result_index;

	task automatic flag_mismatch(input string msg);
		$display("MISMATCH at result %0d: %s", result_index, msg);
		mismatch_count++;
	endtask

	// apply one operation to the model queue and return its result
	function automatic queue_result_t apply_queue_op(op_t op, logic [31:0] prio,
			logic [15:0] sym, logic [11:0] c0, logic [11:0] c1);
		queue_result_t r;
		entry_t        e;
		int            pos;
		r = '{st: ST_OK, prio: '0, sym: '0, c0: '0, c1: '0, count: '0};
		if (op == OP_OFFER) begin
			offer_count++;
			if (held_entries.size() >= QUEUE_DEPTH) begin
				r.st = ST_FULL;
				full_count++;
			end else begin
				e.prio = prio;
				e.sym  = sym;
				e.c0   = c0[HANDLE_WIDTH-1:0];
				e.c1   = c1[HANDLE_WIDTH-1:0];
				// goes behind every entry whose priority is not greater
				pos = held_entries.size();
				while (pos > 0 && held_entries[pos-1].prio > prio)
					pos--;
				held_entries.insert(pos, e);
				if (held_entries.size() > peak_depth)
					peak_depth = held_entries.size();
			end
		end else begin
			poll_count++;
			if (held_entries.size() == 0) begin
				r.st = ST_EMPTY;
				empty_count++;
			end else begin
				e      = held_entries.pop_front();
				r.prio = e.prio;
				r.sym  = e.sym;
				r.c0   = 12'(e.c0);
				r.c1   = 12'(e.c1);
			end
		end
		r.count = 9'(held_entries.size());
		return r;
	endfunction

	// predict on input transfers, compare on output transfers
	always @(posedge clk or negedge arst_n) begin
		queue_result_t want;
		if (!arst_n) begin
			held_entries.delete();
			expected_results.delete();
			mismatch_count <= 0;
			pending_count  <= 0;
			offer_count    <= 0;
			poll_count     <= 0;
			empty_count    <= 0;
			full_count     <= 0;
			peak_depth     <= 0;
			result_index   <= 0;
		end else begin
			if (in_valid && in_ready)
				expected_results.push_back(apply_queue_op(op_t'(operation), priority_req,
					symbol, child_zero, child_one));
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					flag_mismatch("result transfer with nothing expected");
				end else begin
					want = expected_results.pop_front();
					if (status !== want.st)
						flag_mismatch($sformatf("status expected %0d got %0d",
							want.st, status));
					if (out_priority !== want.prio)
						flag_mismatch($sformatf("out_priority expected %h got %h",
							want.prio, out_priority));
					if (out_symbol !== want.sym)
						flag_mismatch($sformatf("out_symbol expected %h got %h",
							want.sym, out_symbol));
					if (out_child_zero !== want.c0)
						flag_mismatch($sformatf("out_child_zero expected %h got %h",
							want.c0, out_child_zero));
					if (out_child_one !== want.c1)
						flag_mismatch($sformatf("out_child_one expected %h got %h",
							want.c1, out_child_one));
					if (entry_count !== want.count)
						flag_mismatch($sformatf("entry_count expected %0d got %0d",
							want.count, entry_count));
				end
				result_index++;
			end
			pending_count <= expected_results.size();
		end
	end

endmodule

// ===== dv/stable_min_priority_queue_unit_tb.sv =====
module stable_min_priority_queue_unit_tb;
	import smpq_pkg::*;

	localparam int TOTAL_ITEMS  = 1575;
	localparam int CALM_ITEMS   = 200;
	localparam int LONG_HOLD    = 400;
	localparam int CYCLE_LIMIT  = 200000;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	op_t         operation;
	logic [31:0] priority_req;
	logic [15:0] symbol;
	logic [11:0] child_zero;
	logic [11:0] child_one;
	logic        out_valid;
	logic        out_ready;
	logic [1:0]  status;
	logic [31:0] out_priority;
	logic [15:0] out_symbol;
	logic [11:0] out_child_zero;
	logic [11:0] out_child_one;
	logic [8:0]  entry_count;

	int unsigned mismatch_count;
	int unsigned pending_count;
	int unsigned offer_count;
	int unsigned poll_count;
	int unsigned empty_count;
	int unsigned full_count;
	int unsigned peak_depth;

	int unsigned sent_count = 0;
	int unsigned depth_guess = 0;
	int unsigned idle_odds = 0;
	int unsigned cycle_count = 0;
	bit          calm = 1'b0;
	bit          held_off = 1'b0;

	stable_min_priority_queue_unit DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.priority_req   (priority_req),
		.symbol         (symbol),
		.child_zero     (child_zero),
		.child_one      (child_one),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.out_priority   (out_priority),
		.out_symbol     (out_symbol),
		.out_child_zero (out_child_zero),
		.out_child_one  (out_child_one),
		.entry_count    (entry_count)
	);

	smpq_result_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.operation      (operation),
		.priority_req   (priority_req),
		.symbol         (symbol),
		.child_zero     (child_zero),
		.child_one      (child_one),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.out_priority   (out_priority),
		.out_symbol     (out_symbol),
		.out_child_zero (out_child_zero),
		.out_child_one  (out_child_one),
		.entry_count    (entry_count),
		.mismatch_count (mismatch_count),
		.pending_count  (pending_count),
		.offer_count    (offer_count),
		.poll_count     (poll_count),
		.empty_count    (empty_count),
		.full_count     (full_count),
		.peak_depth     (peak_depth)
	);

	// clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("DONE: errors detected");
			$finish;
		end
	end

	// half the keys from narrow ranges so ties are common, plus extremes and fully random keys
	function automatic logic [31:0] pick_priority();
		case ($urandom_range(0, 7))
			0:       return 32'h0;
			1:       return 32'hffff_ffff;
			2, 3, 4: return $urandom_range(0, 15);
			5:       return $urandom_range(32'h8000_0000, 32'h8000_0003);
			default: return $urandom;
		endcase
	endfunction

	// present one operation, hold it until the transfer, then maybe go idle
	task automatic push_item(input op_t op, input logic [31:0] prio, input logic [15:0] sym,
			input logic [11:0] c0, input logic [11:0] c1);
		operation    <= op;
		priority_req <= prio;
		symbol       <= sym;
		child_zero   <= c0;
		child_one    <= c1;
		in_valid     <= 1'b1;
		do @(posedge clk); while (!in_ready);
		sent_count++;
		if (op == OP_OFFER && depth_guess < QUEUE_DEPTH)
			depth_guess++;
		else if (op == OP_POLL && depth_guess > 0)
			depth_guess--;
		if (sent_count >= TOTAL_ITEMS - CALM_ITEMS)
			calm = 1'b1;
		if (!calm && idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
	endtask

	task automatic random_item(input op_t op);
		push_item(op, pick_priority(), 16'($urandom_range(0, 16'hffff)),
			12'($urandom_range(0, 12'hfff)), 12'($urandom_range(0, 12'hfff)));
	endtask

	// receiver: random stalls, one long hold-off, always ready near the end
	initial begin
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (!held_off && !calm && sent_count >= 300) begin
				held_off = 1'b1;
				out_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 3) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 10)) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
	end

	// stimulus and verdict
	initial begin
		int unsigned episode;
		int unsigned run_len;
		int unsigned poll_pct;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		operation    = OP_OFFER;
		priority_req = '0;
		symbol       = '0;
		child_zero   = '0;
		child_one    = '0;
		episode      = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty poll, field extremes, equal-priority order, drain to empty
		idle_odds = 4;
		push_item(OP_POLL, 32'h0, 16'h0, 12'h0, 12'h0);
		push_item(OP_OFFER, 32'h0, 16'hffff, 12'hfff, 12'h000);
		push_item(OP_OFFER, 32'hffff_ffff, 16'h0000, 12'h000, 12'hfff);
		push_item(OP_OFFER, 32'd5, 16'h0001, 12'h001, 12'h001);
		push_item(OP_OFFER, 32'd5, 16'h0002, 12'h002, 12'h002);
		push_item(OP_OFFER, 32'd5, 16'h0003, 12'h003, 12'h003);
		push_item(OP_OFFER, 32'h8000_0000, 16'haaaa, 12'h555, 12'haaa);
		push_item(OP_OFFER, 32'h7fff_ffff, 16'h5555, 12'haaa, 12'h555);
		push_item(OP_OFFER, 32'hffff_ffff, 16'h1234, 12'h800, 12'h7ff);
		repeat (9) push_item(OP_POLL, 32'hffff_ffff, 16'hffff, 12'hfff, 12'hfff);
		push_item(OP_POLL, 32'h0, 16'h0, 12'h0, 12'h0);

		// random episodes: periodic fill to full and drain, mixed traffic in between
		while (sent_count < TOTAL_ITEMS) begin
			episode++;
			idle_odds = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(3, 8);
			if (episode % 6 == 1) begin
				while (depth_guess < QUEUE_DEPTH && sent_count < TOTAL_ITEMS)
					random_item(OP_OFFER);
				// offers against a full queue get refused
				repeat ($urandom_range(2, 5))
					if (sent_count < TOTAL_ITEMS)
						random_item(OP_OFFER);
			end else if (episode % 6 == 2) begin
				while (depth_guess > 0 && sent_count < TOTAL_ITEMS)
					random_item(OP_POLL);
				repeat (2)
					if (sent_count < TOTAL_ITEMS)
						random_item(OP_POLL);
			end else begin
				run_len  = $urandom_range(10, 60);
				poll_pct = $urandom_range(0, 2) * 30 + 20;
				repeat (run_len)
					if (sent_count < TOTAL_ITEMS)
						random_item(($urandom_range(1, 100) <= poll_pct) ?
							OP_POLL : OP_OFFER);
			end
		end
		in_valid <= 1'b0;

		// let the remaining results drain, then watch for strays
		while (pending_count != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		$display("covered %0d offers (%0d refused when full) and %0d polls (%0d on empty)",
			offer_count, full_count, poll_count, empty_count);
		$display("peak depth %0d of %0d, %0d cycles", peak_depth, QUEUE_DEPTH, cycle_count);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/smpq_pkg.sv
rtl/smpq_cell.sv
rtl/stable_min_priority_queue_unit.sv
dv/smpq_result_checker.sv
dv/stable_min_priority_queue_unit_tb.sv
